@@ rtl/core/union_find_edge_merger_assert.svh @@
// Assertion macros shared by the checker of the union-find edge merger.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef UNION_FIND_EDGE_MERGER_ASSERT_SVH
`define UNION_FIND_EDGE_MERGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define UFEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define UFEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define UFEM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ufem_pkg.sv @@
// Shared types and constants of the union-find edge merger.
// No dependencies; every other file of the block but the assertion macro header imports this package.
`default_nettype none

package ufem_pkg;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 10;
  localparam int SUM_W    = 26;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_LINK,
    ST_DONE
  } ufem_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ufem_mem_ctl_t;

  typedef struct packed {
    logic finish;
    logic accepted;
  } ufem_evt_t;

endpackage

`default_nettype wire

@@ rtl/core/ufem_ifs.sv @@
// Valid/ready channel interfaces for edge items and result items.
// Depends on ufem_pkg for the field widths.
`default_nettype none

interface ufem_in_if import ufem_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, output node_a, output node_b, output weight, input ready);
  modport sink   (input valid, input node_a, input node_b, input weight, output ready);
endinterface

interface ufem_out_if import ufem_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [COUNT_W-1:0] joined_count;
  logic [SUM_W-1:0]   total_weight;

  modport source (output valid, output accepted, output joined_count, output total_weight,
                  input ready);
  modport sink   (input valid, input accepted, input joined_count, input total_weight,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/ufem_table.sv @@
// Parent table: one write port and one registered read port.
// Depends on ufem_pkg for the port control struct.
`default_nettype none

module ufem_table import ufem_pkg::*; #(
  parameter int AW    = 10,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  ufem_mem_ctl_t ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/ufem_walker.sv @@
// Sequencer that walks and compresses parent chains and links roots.
// Depends on ufem_pkg; drives the ports of ufem_table.
`default_nettype none

module ufem_walker import ufem_pkg::*; #(
  parameter int NODES = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_valid,
  output logic              start_ready,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic              full,
  input  logic              slot_free,
  output ufem_mem_ctl_t     mem_ctl,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     wr_data,
  input  logic [AW-1:0]     rd_data,
  output ufem_evt_t         evt
);

  localparam logic [16:0]   NODES_L = 17'(NODES);
  localparam logic [AW-1:0] LAST    = AW'(NODES - 1);

  ufem_state_t   state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] root_r, root_nxt;
  logic [AW-1:0] root_hi_r, root_hi_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic          phase_r, phase_nxt;
  logic          acc_r, acc_nxt;

  logic          take;
  logic          in_range;
  logic          walk_go;
  logic [AW-1:0] hi_in, lo_in;
  logic [AW-1:0] start_sel;
  logic          at_root;
  logic          at_top;

  assign start_ready = (state_r == ST_IDLE);
  assign take        = start_valid && start_ready;
  assign in_range    = ({7'b0, node_a} < NODES_L) && ({7'b0, node_b} < NODES_L);
  assign walk_go     = in_range && !full;
  assign hi_in       = (node_a > node_b) ? AW'(node_a) : AW'(node_b);
  assign lo_in       = (node_a > node_b) ? AW'(node_b) : AW'(node_a);
  assign start_sel   = phase_r ? lo_r : hi_r;
  // the shared compare: parent read back against the node it came from
  assign at_root     = (rd_data == cur_r);
  assign at_top      = (cur_r == root_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (take) state_nxt = walk_go ? ST_FIND : ST_DONE;
      ST_FIND:  if (at_root) state_nxt = ST_COMP;
      ST_COMP:  if (at_top) state_nxt = phase_r ? ST_LINK : ST_FIND;
      ST_LINK:  state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // table port, datapath and events
  always_comb begin
    mem_ctl      = '0;
    rd_addr      = cur_r;
    wr_addr      = cur_r;
    wr_data      = root_r;
    evt          = '0;
    clr_nxt      = clr_r;
    cur_nxt      = cur_r;
    root_nxt     = root_r;
    root_hi_nxt  = root_hi_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = clr_r;
        wr_data       = clr_r;
        clr_nxt       = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (take) begin
          acc_nxt   = 1'b0;
          hi_nxt    = hi_in;
          lo_nxt    = lo_in;
          phase_nxt = 1'b0;
          cur_nxt   = hi_in;
          if (walk_go) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = hi_in;
          end
        end
      end
      ST_FIND: begin
        mem_ctl.rd_en = 1'b1;
        if (at_root) begin
          root_nxt = cur_r;
          cur_nxt  = start_sel;
          rd_addr  = start_sel;
        end else begin
          cur_nxt  = rd_data;
          rd_addr  = rd_data;
        end
      end
      ST_COMP: begin
        if (at_top) begin
          if (!phase_r) begin
            root_hi_nxt   = root_r;
            phase_nxt     = 1'b1;
            cur_nxt       = lo_r;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = lo_r;
          end
        end else begin
          // point this node straight at its root, then follow its old parent
          mem_ctl.wr_en = 1'b1;
          mem_ctl.rd_en = 1'b1;
          wr_addr       = cur_r;
          wr_data       = root_r;
          rd_addr       = rd_data;
          cur_nxt       = rd_data;
        end
      end
      ST_LINK: begin
        if (root_hi_r != root_r) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = (root_hi_r > root_r) ? root_hi_r : root_r;
          wr_data       = (root_hi_r > root_r) ? root_r : root_hi_r;
          acc_nxt       = 1'b1;
        end
      end
      ST_DONE: begin
        evt.finish   = slot_free;
        evt.accepted = acc_r;
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    root_r    <= root_nxt;
    root_hi_r <= root_hi_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    phase_r   <= phase_nxt;
    acc_r     <= acc_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/ufem_accum.sv @@
// Joined-edge counter and saturating weight total.
// Depends on ufem_pkg for widths, limits and the event struct.
`default_nettype none

module ufem_accum import ufem_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [WEIGHT_W-1:0] weight,
  input  ufem_evt_t           evt,
  output logic                full,
  output logic [COUNT_W-1:0]  count_upd,
  output logic [SUM_W-1:0]    sum_upd
);

  localparam int CAP_I = (NODES < int'(COUNT_MAX)) ? NODES : int'(COUNT_MAX);
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_I);

  logic [COUNT_W-1:0]  count_r;
  logic [SUM_W-1:0]    sum_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [SUM_W:0]      sum_wide;
  logic                bump;

  assign full     = (count_r >= CAP);
  assign bump     = evt.finish && evt.accepted;
  assign sum_wide = {1'b0, sum_r} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, weight_r};

  always_comb begin
    count_upd = count_r;
    sum_upd   = sum_r;
    if (bump) begin
      count_upd = count_r + 1'b1;
      sum_upd   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_upd;
      sum_r   <= sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      weight_r <= weight;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/union_find_edge_merger.sv @@
// Top level of the union-find edge merger (Kruskal edge acceptor).
// Depends on ufem_pkg, ufem_ifs, ufem_table, ufem_walker and ufem_accum.
//
//   channel  direction  payload                                  transfer when
//   in_ch    sink       node_a[9:0] node_b[9:0] weight[15:0]     valid && ready
//   out_ch   source     accepted joined_count[9:0] total[25:0]   valid && ready
//
// Sequence: an edge whose node is out of range, or that arrives once the tree is
//   complete, goes from idle straight to done without a walk. A walked edge
//   follows the parent chain from each end to its root: every chain
//   step is one read of the parent table through its single read port.
// Reset: synchronous, active low; afterwards a clearing pass writes every table
//   entry with its own index, with in_ch.ready low throughout.
// Stalls: the result register holds a result until out_ch takes it; in_ch is
//   ready whenever the sequencer is idle, even while a result still waits.
`default_nettype none

module union_find_edge_merger import ufem_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  ufem_in_if.sink    in_ch,
  ufem_out_if.source out_ch
);

  localparam int AW = $clog2(NODES);

  ufem_mem_ctl_t      mem_ctl;
  logic [AW-1:0]      rd_addr, wr_addr, wr_data, rd_data;
  ufem_evt_t          evt;
  logic               full;
  logic               slot_free;
  logic               take;
  logic [COUNT_W-1:0] count_upd;
  logic [SUM_W-1:0]   sum_upd;

  logic               out_valid_r, out_valid_nxt;
  logic               out_acc_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [SUM_W-1:0]   out_sum_r;

  // an edge transfers only while the sequencer is idle
  assign take      = in_ch.valid && in_ch.ready;
  // the result register can take a new result when empty or being drained
  assign slot_free = !out_valid_r || out_ch.ready;

  ufem_table #(
    .AW    (AW),
    .DEPTH (NODES)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  ufem_walker #(
    .NODES (NODES),
    .AW    (AW)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_valid (in_ch.valid),
    .start_ready (in_ch.ready),
    .node_a      (in_ch.node_a),
    .node_b      (in_ch.node_b),
    .full        (full),
    .slot_free   (slot_free),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data),
    .evt         (evt)
  );

  ufem_accum #(
    .NODES (NODES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .weight    (in_ch.weight),
    .evt       (evt),
    .full      (full),
    .count_upd (count_upd),
    .sum_upd   (sum_upd)
  );

  // hold the result until the sink takes it; load a fresh one on finish
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (evt.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // counts already include this edge when it is accepted
  always_ff @(posedge clk) begin
    if (evt.finish) begin
      out_acc_r   <= evt.accepted;
      out_count_r <= count_upd;
      out_sum_r   <= sum_upd;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.joined_count = out_count_r;
  assign out_ch.total_weight = out_sum_r;

endmodule

`default_nettype wire

@@ rtl/core/ufem_checker.sv @@
// Port-level checker of the union-find edge merger, bound to the top level.
// Depends on ufem_pkg and the macros in union_find_edge_merger_assert.svh.
`default_nettype none

`include "union_find_edge_merger_assert.svh"

module ufem_checker import ufem_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_accepted,
  input logic [COUNT_W-1:0] out_joined_count,
  input logic [SUM_W-1:0]   out_total_weight
);

  // a stalled result holds its value
  `UFEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_accepted) && $stable(out_joined_count) && $stable(out_total_weight), "result changed while stalled")

  // one edge at a time: ready drops right after a transfer
  `UFEM_ASSERT_NEXT(a_one_edge, in_valid && in_ready, !in_ready, "second edge taken while busy")

  // the clearing pass keeps the input closed after reset
  `UFEM_ASSERT_ALWAYS(a_clear_closed, !rst_n, !in_ready, "edge taken during table clear")

  // an accepted edge is always counted
  `UFEM_ASSERT_NOW(a_count_live, out_valid && out_accepted, out_joined_count != '0, "accepted edge with zero count")

endmodule

bind union_find_edge_merger ufem_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_joined_count (out_ch.joined_count),
  .out_total_weight (out_ch.total_weight)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking bench for the union-find edge merger (Kruskal edge acceptor).
// Depends on ufem_pkg, ufem_ifs and the union_find_edge_merger top level; it
// predicts each result with its own disjoint-set forest and compares in order.
`default_nettype none

module tb_top;
  import ufem_pkg::*;

  localparam int NODES        = 1024;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } edge_item_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] joined_count;
    logic [SUM_W-1:0]   total_weight;
  } merge_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  ufem_in_if  edge_ch ();
  ufem_out_if merge_ch ();

  union_find_edge_merger #(
    .NODES (NODES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (edge_ch),
    .out_ch (merge_ch)
  );

  // Bench-side drive registers; every block input is known from time zero.
  logic       send_valid = 1'b0;
  edge_item_t send_edge  = '0;
  logic       take_ready = 1'b0;

  assign edge_ch.valid  = send_valid;
  assign edge_ch.node_a = send_edge.node_a;
  assign edge_ch.node_b = send_edge.node_b;
  assign edge_ch.weight = send_edge.weight;
  assign merge_ch.ready = take_ready;

  edge_item_t    pending_edges[$];
  merge_result_t awaited_merges[$];

  // Shadow of the block's state: parent links, joined-edge count, weight sum.
  logic [NODE_W-1:0]  forest [NODES];
  logic [COUNT_W-1:0] joins_so_far;
  logic [SUM_W-1:0]   weight_total;

  int unsigned edge_total    = 0;
  int unsigned edges_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;
  int unsigned loaded        = 0;
  int unsigned send_wait     = 0;
  int unsigned take_wait     = 0;
  logic        edge_took     = 1'b0;
  logic        take_done     = 1'b0;
  logic        hold_off      = 1'b0;

  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at result %0d: %s", results_seen, what);
  endtask

  // Pacing: in windows of 48 transfers, one window in three carries back-to-back
  // traffic and the other two carry random gaps.
  function automatic int unsigned pace_gap(input int unsigned seq);
    if ((seq / 48) % 3 == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Find the root of a node and point every node on its path straight at it.
  function automatic logic [NODE_W-1:0] root_of_node(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] nxt;
    int                steps;
    root  = n;
    steps = 0;
    while (forest[root] != root && steps < NODES) begin
      root = forest[root];
      steps++;
    end
    cur   = n;
    steps = 0;
    while (cur != root && steps < NODES) begin
      nxt         = forest[cur];
      forest[cur] = root;
      cur         = nxt;
      steps++;
    end
    return root;
  endfunction

  // Apply one edge to the shadow forest and return the result it causes.
  function automatic merge_result_t merge_edge(input edge_item_t e);
    logic [NODE_W-1:0] hi;
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] r_hi;
    logic [NODE_W-1:0] r_lo;
    logic [SUM_W:0]    wide;
    merge_result_t     res;
    res.accepted = 1'b0;
    // Reject out-of-table nodes and anything after the tree is complete.
    if (int'(e.node_a) < NODES && int'(e.node_b) < NODES &&
        int'(joins_so_far) < NODES && joins_so_far != COUNT_MAX) begin
      hi   = (e.node_a > e.node_b) ? e.node_a : e.node_b;
      lo   = (e.node_a > e.node_b) ? e.node_b : e.node_a;
      r_hi = root_of_node(hi);
      r_lo = root_of_node(lo);
      if (r_hi != r_lo) begin
        // Hang the larger root under the smaller one.
        if (r_hi > r_lo) forest[r_hi] = r_lo;
        else             forest[r_lo] = r_hi;
        joins_so_far = joins_so_far + 1'b1;
        wide         = {1'b0, weight_total} + e.weight;
        weight_total = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
        res.accepted = 1'b1;
      end
    end
    res.joined_count = joins_so_far;
    res.total_weight = weight_total;
    return res;
  endfunction

  function automatic void add_edge(input int a, input int b, input int w);
    edge_item_t e;
    e.node_a = a[NODE_W-1:0];
    e.node_b = b[NODE_W-1:0];
    e.weight = w[WEIGHT_W-1:0];
    pending_edges = {pending_edges, e};
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int perm [NODES];
    int j;
    int tmp;
    int w;
    int pick;

    for (int i = 0; i < NODES; i++) forest[i] = i[NODE_W-1:0];
    joins_so_far = '0;
    weight_total = '0;

    // Directed part: self loops at both ends of the node range, extreme
    // nodes and weights, reversed repeats that must be rejected, and a
    // deliberately deep parent chain walked end to end.
    add_edge(0, 0, 0);
    add_edge(1023, 1023, 0);
    add_edge(0, 1023, 1);
    add_edge(1023, 0, 1);
    add_edge('h155, 'h2AA, 2);
    add_edge('h2AA, 'h155, 2);
    // Link roots in falling order so 31 -> 30 -> ... -> 24 forms one chain.
    for (int k = 30; k >= 24; k--) add_edge(k, k + 1, 3);
    add_edge(31, 1000, 4);
    add_edge(24, 31, 4);
    add_edge(1023, 'h155, 5);
    add_edge(512, 511, 65535);
    add_edge(511, 512, 65535);
    add_edge(1000, 1023, 65535);

    // Random part: a random spanning tree over a shuffled node order, so
    // that every edge of it joins the forest a little further and the tree
    // completes near the end; noise edges (random pairs, self loops,
    // repeats) fall between tree edges.
    for (int i = 0; i < NODES; i++) perm[i] = i;
    for (int i = NODES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    w = 0;
    for (int i = 1; i < NODES; i++) begin
      w = w + $urandom_range(0, 110);
      if (w > 65535) w = 65535;
      if ($urandom_range(0, 99) < 22) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: add_edge(perm[$urandom_range(0, i - 1)], perm[$urandom_range(0, i - 1)], w);
          1: begin
            tmp = $urandom_range(0, NODES - 1);
            add_edge(tmp, tmp, w);
          end
          2: add_edge($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                      $urandom_range(0, 65535));
          default: add_edge($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), w);
        endcase
      end
      // Near neighbors in the shuffled order tend to build longer chains.
      if ($urandom_range(0, 9) < 4) j = $urandom_range((i > 4) ? i - 4 : 0, i - 1);
      else                          j = $urandom_range(0, i - 1);
      if ($urandom_range(0, 1) == 0) add_edge(perm[i], perm[j], w);
      else                           add_edge(perm[j], perm[i], w);
    end
    // Tree complete: these must all be rejected with the counts frozen.
    for (int i = 0; i < 12; i++)
      add_edge($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
               (i % 2 == 0) ? 65535 : $urandom_range(0, 65535));
    edge_total = pending_edges.size();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last transfer in and its result out, then let any stray
    // output show itself.
    do @(negedge clk);
    while (edges_taken != edge_total || awaited_merges.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) $display("Verification passed");
    else                     $display("Verification failed");
    $finish;
  end

  // Watchdog: covers the clearing pass, every long walk and both hold-offs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Edge driver: hold an offered item until its transfer, then wait out the
  // gap drawn for it before offering the next one.
  always @(negedge clk) begin
    edge_item_t nxt;
    if (!rst_n) begin
      send_valid <= 1'b0;
      send_wait  <= 0;
    end else if (send_valid && !edge_took) begin
      // hold: the block has not taken this edge yet
    end else if (send_wait != 0) begin
      send_valid <= 1'b0;
      send_wait  <= send_wait - 1;
    end else if (pending_edges.size() != 0) begin
      nxt        = pending_edges.pop_front();
      send_edge  <= nxt;
      send_valid <= 1'b1;
      send_wait  <= pace_gap(loaded);
      loaded     <= loaded + 1;
    end else begin
      send_valid <= 1'b0;
    end
  end

  // Result receiver: after each transfer drop ready for a drawn number of
  // cycles; a hold-off overrides everything.
  always @(negedge clk) begin
    int unsigned gap;
    if (!rst_n) begin
      take_ready <= 1'b0;
      take_wait  <= 0;
    end else if (hold_off) begin
      take_ready <= 1'b0;
    end else if (take_done) begin
      gap        = pace_gap(results_seen);
      take_ready <= (gap == 0);
      take_wait  <= gap;
    end else if (take_wait > 1) begin
      take_wait  <= take_wait - 1;
      take_ready <= 1'b0;
    end else begin
      take_wait  <= 0;
      take_ready <= 1'b1;
    end
  end

  // Long receiver stalls while the driver keeps offering: the result
  // register fills and the block must stop taking edges.
  initial begin
    for (int k = 0; k < 2; k++) begin
      wait (results_seen >= 60 + k * 640);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Monitor: predict on every edge transfer, check every result transfer
  // against the oldest prediction.
  always @(posedge clk) begin
    merge_result_t want;
    if (!rst_n) begin
      edge_took <= 1'b0;
      take_done <= 1'b0;
    end else begin
      edge_took <= send_valid && edge_ch.ready;
      take_done <= merge_ch.valid && take_ready;
      if (send_valid && edge_ch.ready) begin
        awaited_merges = {awaited_merges, merge_edge(send_edge)};
        edges_taken++;
      end
      if (merge_ch.valid && take_ready) begin
        results_seen++;
        if (awaited_merges.size() == 0) begin
          note_mismatch("result with no edge awaiting one");
        end else begin
          want = awaited_merges.pop_front();
          if (merge_ch.accepted !== want.accepted)
            note_mismatch($sformatf("accepted got %0d want %0d",
                                    merge_ch.accepted, want.accepted));
          if (merge_ch.joined_count !== want.joined_count)
            note_mismatch($sformatf("joined_count got %0d want %0d",
                                    merge_ch.joined_count, want.joined_count));
          if (merge_ch.total_weight !== want.total_weight)
            note_mismatch($sformatf("total_weight got %0d want %0d",
                                    merge_ch.total_weight, want.total_weight));
        end
      end
    end
  end

endmodule

`default_nettype wire
